// ===== design/mks_pkg.sv =====
// Shared types, constants and the key table of the matrix keypad scanner.
package mks_pkg;

    localparam int unsigned ColW   = 4;
    localparam int unsigned RowW   = 4;
    localparam int unsigned CodeW  = 5;
    localparam int unsigned CountW = 16;

    localparam logic [CountW-1:0] DEBOUNCE_RESET = 16'd10;
    localparam logic [CodeW-1:0]  NO_KEY         = 5'd16;
    localparam logic [RowW-1:0]   ALL_ROWS       = 4'hF;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_SCAN     = 2'd2,
        PH_HOLD     = 2'd3
    } phase_t;

    // Code of the key at (row, column).
    function automatic logic [CodeW-1:0] key_lookup(input logic [1:0] row,
                                                    input logic [1:0] col);
        logic [CodeW-1:0] code;
        case ({row, col})
            4'h0: code = 5'd1;
            4'h1: code = 5'd2;
            4'h2: code = 5'd3;
            4'h3: code = 5'd10;
            4'h4: code = 5'd4;
            4'h5: code = 5'd5;
            4'h6: code = 5'd6;
            4'h7: code = 5'd11;
            4'h8: code = 5'd7;
            4'h9: code = 5'd8;
            4'hA: code = 5'd9;
            4'hB: code = 5'd12;
            4'hC: code = 5'd0;
            4'hD: code = 5'd13;
            4'hE: code = 5'd14;
            default: code = 5'd15;
        endcase
        return code;
    endfunction

    // Lowest high column; column 3 when none of 0..2 is high.
    function automatic logic [1:0] lowest_col(input logic [ColW-1:0] cols);
        logic [1:0] c;
        if (cols[0]) begin
            c = 2'd0;
        end else if (cols[1]) begin
            c = 2'd1;
        end else if (cols[2]) begin
            c = 2'd2;
        end else begin
            c = 2'd3;
        end
        return c;
    endfunction

    function automatic logic [RowW-1:0] row_bit(input logic [1:0] r);
        return RowW'(1) << r;
    endfunction

endpackage

// ===== design/matrix_keypad_scanner.sv =====
// Top level of the 4x4 matrix keypad scanner: tick-driven scan state machine.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata: column_levels
//  m_       out        m_tvalid/m_tready  m_tdata: row_drive, key_code; m_tuser: key_valid
//  cfg_     in         cfg_wen            cfg_wdata: debounce_ticks
//
// One tick item per cycle while the result is not stalled: the state update and key
// table lookup sit between the state registers and the result register.
// Reset (aresetn low, synchronous) returns to idle with debounce_ticks at 10.
// A stalled result holds in the result register; input is taken while the
// result register is empty or being read in the same cycle.
module matrix_keypad_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,  // debounce_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [3:0] column_levels, [7:4] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [3:0] row_drive, [8:4] key_code, [15:9] zero
    output logic        m_tuser     // [0] key_valid
);
    import mks_pkg::*;

    logic [CountW-1:0] debounce_reg;
    phase_t            phase_reg, phase_next;
    logic [1:0]        scan_row_reg, scan_row_next;
    logic [1:0]        held_col_reg, held_col_next;
    logic [CountW-1:0] wait_reg, wait_next;
    logic [CodeW-1:0]  pending_reg, pending_next;

    logic              out_valid_reg;
    logic [RowW-1:0]   drive_reg, drive_next;
    logic              key_valid_reg, key_valid_next;
    logic [CodeW-1:0]  code_reg, code_next;

    logic [ColW-1:0]   cols;
    logic              s_xfer;

    assign cols     = s_tdata[ColW-1:0];
    assign s_tready = !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    // Next state.
    always_comb begin
        phase_next    = phase_reg;
        scan_row_next = scan_row_reg;
        held_col_next = held_col_reg;
        wait_next     = wait_reg;
        pending_next  = pending_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (cols != '0) begin
                    wait_next  = debounce_reg;
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - CountW'(1);
                end else if (cols != '0) begin
                    scan_row_next = 2'd0;
                    phase_next    = PH_SCAN;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_SCAN: begin
                if (cols != '0) begin
                    held_col_next = lowest_col(cols);
                    pending_next  = key_lookup(scan_row_reg, lowest_col(cols));
                    phase_next    = PH_HOLD;
                end else if (scan_row_reg == 2'd3) begin
                    scan_row_next = 2'd0;
                    phase_next    = PH_IDLE;
                end else begin
                    scan_row_next = scan_row_reg + 2'd1;
                end
            end
            PH_HOLD: begin
                if (!cols[held_col_reg]) begin
                    pending_next = NO_KEY;
                    phase_next   = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Result of this tick.
    always_comb begin
        drive_next     = ALL_ROWS;
        key_valid_next = 1'b0;
        code_next      = NO_KEY;
        case (phase_reg)
            PH_IDLE: drive_next = ALL_ROWS;
            PH_DEBOUNCE: begin
                if (wait_reg == '0 && cols != '0) begin
                    drive_next = row_bit(2'd0);
                end
            end
            PH_SCAN: begin
                if (cols != '0) begin
                    drive_next = row_bit(scan_row_reg);
                end else if (scan_row_reg != 2'd3) begin
                    drive_next = row_bit(scan_row_reg + 2'd1);
                end
            end
            PH_HOLD: begin
                if (!cols[held_col_reg]) begin
                    key_valid_next = 1'b1;
                    code_next      = pending_reg;
                end else begin
                    drive_next = row_bit(scan_row_reg);
                end
            end
            default: drive_next = ALL_ROWS;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RESET;
            phase_reg     <= PH_IDLE;
            scan_row_reg  <= 2'd0;
            held_col_reg  <= 2'd0;
            wait_reg      <= '0;
            pending_reg   <= NO_KEY;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                debounce_reg <= cfg_wdata;
            end
            if (s_xfer) begin
                phase_reg     <= phase_next;
                scan_row_reg  <= scan_row_next;
                held_col_reg  <= held_col_next;
                wait_reg      <= wait_next;
                pending_reg   <= pending_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; hold while stalled.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            drive_reg     <= drive_next;
            key_valid_reg <= key_valid_next;
            code_reg      <= code_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, code_reg, drive_reg};
    assign m_tuser  = key_valid_reg;

    // A reported key carries a real code; otherwise the code reads no key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser ? (code_reg != NO_KEY) : (code_reg == NO_KEY)))
        else $error("key code does not match key_valid");

    // While holding, a key code is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HOLD) |-> (pending_reg != NO_KEY))
        else $error("hold phase without pending code");

    // Release of the held column reports the key and returns to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && phase_reg == PH_HOLD && !cols[held_col_reg])
        |=> (m_tvalid && m_tuser && phase_reg == PH_IDLE && pending_reg == NO_KEY))
        else $error("release not reported");

    // A report only comes out of the hold phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && phase_reg != PH_HOLD) |=> (m_tvalid && !m_tuser))
        else $error("key reported outside hold");

endmodule

// ===== bench/tb_matrix_keypad_scanner.sv =====
// Self-checking bench for the keypad scanner: tick stimulus, scan prediction, result compare.
`timescale 1ns / 100ps

module tb_matrix_keypad_scanner;
    import mks_pkg::*;

    typedef struct packed {
        logic [RowW-1:0]  rows;
        logic             valid;
        logic [CodeW-1:0] code;
    } keyscan_result_t;

    class keypad_scoreboard;
        phase_t            phase;
        logic [1:0]        scan_row;
        logic [1:0]        held_col;
        logic [CountW-1:0] wait_count;
        logic [CountW-1:0] debounce;
        logic [CodeW-1:0]  pending_code;
        logic [RowW-1:0]   next_rows;
        logic [CodeW-1:0]  key_codes [16];
        keyscan_result_t   expected_results [$];
        int unsigned       mismatches;

        function new();
            phase        = PH_IDLE;
            scan_row     = 2'd0;
            held_col     = 2'd0;
            wait_count   = '0;
            debounce     = DEBOUNCE_RESET;
            pending_code = NO_KEY;
            next_rows    = ALL_ROWS;
            mismatches   = 0;
            // indexed by {row, column}
            key_codes = '{5'd1, 5'd2, 5'd3, 5'd10,
                          5'd4, 5'd5, 5'd6, 5'd11,
                          5'd7, 5'd8, 5'd9, 5'd12,
                          5'd0, 5'd13, 5'd14, 5'd15};
        endfunction

        // Advance the scan state by one tick and queue the result it produces.
        function void note_columns(input logic [ColW-1:0] cols);
            keyscan_result_t r;
            r.rows  = ALL_ROWS;
            r.valid = 1'b0;
            r.code  = NO_KEY;
            case (phase)
                PH_IDLE: begin
                    if (cols != '0) begin
                        wait_count = debounce;
                        phase      = PH_DEBOUNCE;
                    end
                end
                PH_DEBOUNCE: begin
                    if (wait_count != '0) begin
                        wait_count = wait_count - 1'b1;
                    end else if (cols != '0) begin
                        scan_row = 2'd0;
                        phase    = PH_SCAN;
                        r.rows   = 4'b0001;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_SCAN: begin
                    if (cols != '0) begin
                        held_col = 2'd3;
                        for (int c = 2; c >= 0; c--) begin
                            if (cols[c[1:0]]) held_col = c[1:0];
                        end
                        pending_code = key_codes[{scan_row, held_col}];
                        phase        = PH_HOLD;
                        r.rows       = 4'b0001 << scan_row;
                    end else if (scan_row == 2'd3) begin
                        scan_row = 2'd0;
                        phase    = PH_IDLE;
                    end else begin
                        scan_row = scan_row + 2'd1;
                        r.rows   = 4'b0001 << scan_row;
                    end
                end
                default: begin
                    // only the held column matters while the key is down
                    if (!cols[held_col]) begin
                        r.valid      = 1'b1;
                        r.code       = pending_code;
                        pending_code = NO_KEY;
                        phase        = PH_IDLE;
                    end else begin
                        r.rows = 4'b0001 << scan_row;
                    end
                end
            endcase
            next_rows = r.rows;
            expected_results.push_back(r);
        endfunction

        task report(input string msg);
            if (mismatches < 100) $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(input logic [15:0] tdata, input logic tuser);
            keyscan_result_t want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with none expected: tdata=%h tuser=%b", tdata, tuser));
            end else begin
                want = expected_results.pop_front();
                if (tdata[3:0] !== want.rows)
                    report($sformatf("row_drive %b, expected %b", tdata[3:0], want.rows));
                if (tuser !== want.valid)
                    report($sformatf("key_valid %b, expected %b", tuser, want.valid));
                if (tdata[8:4] !== want.code)
                    report($sformatf("key_code %0d, expected %0d", tdata[8:4], want.code));
            end
        endtask
    endclass

    localparam int unsigned STALL_LIMIT = 2000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [3:0] column_levels, [7:4] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [3:0] row_drive, [8:4] key_code, [15:9] zero
    logic        m_tuser;          // [0] key_valid

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    keypad_scoreboard sb = new();

    logic [ColW-1:0] directed_cols [16] = '{
        4'b1010, 4'b1010, 4'b0000, 4'b0000, 4'b0000, 4'b0000,  // scan all rows, nothing
        4'b1000, 4'b1000, 4'b0000, 4'b1100, 4'b0100, 4'b1011,  // two columns in row 1
        4'b0001, 4'b0001, 4'b0001, 4'b0000                     // row 0, column 0
    };

    matrix_keypad_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("matrix_keypad_scanner verification failed");
            $finish;
        end
    end

    task automatic send_columns(input logic [ColW-1:0] cols);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, cols};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_columns(cols);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_debounce(input logic [15:0] ticks);
        drain();
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= ticks;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        sb.debounce = ticks;
    endtask

    // Mostly key presses seen through the row drive, some bouncing, some raw noise.
    task automatic run_traffic(input int unsigned item_goal, input int unsigned press_pct);
        int unsigned     sent;
        int unsigned     hold_len;
        int unsigned     gap_len;
        logic [15:0]     pressed;
        logic [ColW-1:0] cols;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(99) < press_pct) begin
                pressed = '0;
                pressed[4'($urandom_range(15))] = 1'b1;
                if ($urandom_range(3) == 0) pressed[4'($urandom_range(15))] = 1'b1;
                hold_len = sb.debounce + $urandom_range(2, 12);
                gap_len  = $urandom_range(1, 4);
                for (int unsigned t = 0; t < hold_len + gap_len; t++) begin
                    cols = '0;
                    if (t < hold_len) begin
                        for (int k = 0; k < 16; k++) begin
                            if (pressed[k[3:0]] && sb.next_rows[k[3:2]]) cols[k[1:0]] = 1'b1;
                        end
                    end
                    if ($urandom_range(99) < 8) cols = ColW'($urandom_range(15));
                    send_columns(cols);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_columns(ColW'($urandom_range(15)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // countdown from the reset value; a write during it only affects the next load
        send_columns(4'b0000);
        send_columns(4'b1111);
        write_debounce(16'd0);
        repeat (5) begin
            send_columns(4'b1111);
            send_columns(4'b0000);
        end
        send_columns(4'b0000);  // nothing high at the check: back to idle
        foreach (directed_cols[i]) send_columns(directed_cols[i]);

        write_debounce(16'd1);
        run_traffic(290, 75);

        write_debounce(16'd3);
        send_idle_pct = 82;
        run_traffic(290, 75);

        write_debounce(16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        run_traffic(290, 75);

        write_debounce(16'd10);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        run_traffic(290, 75);

        // longest countdown: load it and count down a few ticks, no idling
        write_debounce(16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (21) send_columns(4'b0001);

        drain();
        repeat (5) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("matrix_keypad_scanner verification clean");
        end else begin
            $display("matrix_keypad_scanner verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mks_pkg.sv
design/matrix_keypad_scanner.sv
bench/tb_matrix_keypad_scanner.sv
